// File: hdl/tts_pkg.sv
package tts_pkg;

    // field widths
    localparam int KIND_W      = 3;
    localparam int DUR_W       = 16;
    localparam int OUT_W       = 16;
    localparam int SEL_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // request kinds carried on tuser
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ARM_A   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARM_B   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_KILL_B  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MARK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ELAPSED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DELTA   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_DIVIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_WRAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_WRAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HMS_WRAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS    = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_SUB_DIVIDE = 8'd5;
    localparam logic [15:0] RST_TICK_WRAP  = 16'd60000;
    localparam logic [15:0] RST_SEC_WRAP   = 16'd3600;
    localparam logic [15:0] RST_HMS_WRAP   = 16'd36000;
    localparam logic [6:0]  RST_TICK_MS    = 7'd10;

    // time base constants
    localparam int MS_PER_SEC   = 1000;
    localparam int MS_PER_100MS = 100;
    localparam int SEC_PHASE    = 1;
    localparam int HMS_PHASE    = 2;

    // divider operand / writeback select
    localparam logic [SEL_W-1:0] SEL_NONE   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_PHASE  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_TICK   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_SPER   = 4'd3;
    localparam logic [SEL_W-1:0] SEL_HPER   = 4'd4;
    localparam logic [SEL_W-1:0] SEL_SECCHK = 4'd5;
    localparam logic [SEL_W-1:0] SEL_HMSCHK = 4'd6;
    localparam logic [SEL_W-1:0] SEL_SECINC = 4'd7;
    localparam logic [SEL_W-1:0] SEL_HMSINC = 4'd8;
    localparam logic [SEL_W-1:0] SEL_ARM    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_CUR    = 4'd10;
    localparam logic [SEL_W-1:0] SEL_OLD    = 4'd11;

    // controller to datapath
    typedef struct packed {
        logic             load_in;
        logic             apply;
        logic             div_start;
        logic [SEL_W-1:0] div_sel;
        logic             load_out;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic              div_done;
        logic              div_busy;
        logic [KIND_W-1:0] kind;
        logic              phase_zero;
        logic              out_free;
    } t_ctrl_sts;

endpackage

// File: hdl/tts_div.sv
module tts_div #(
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    // one restoring step per cycle
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_dividend < i_divisor) begin
                    // short cut: quotient zero
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(DW);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            if (i_dividend < i_divisor) begin
                r_rem <= i_dividend;
                r_quo <= '0;
            end else begin
                r_rem <= '0;
                r_quo <= i_dividend;
            end
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: hdl/tts_ctrl.sv
module tts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tts_pkg::t_ctrl_sts    i_sts,
    output tts_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_PHASE  = 4'd2;
    localparam logic [3:0] ST_PCHK   = 4'd3;
    localparam logic [3:0] ST_TICK   = 4'd4;
    localparam logic [3:0] ST_SPER   = 4'd5;
    localparam logic [3:0] ST_HPER   = 4'd6;
    localparam logic [3:0] ST_SECCHK = 4'd7;
    localparam logic [3:0] ST_HMSCHK = 4'd8;
    localparam logic [3:0] ST_SECINC = 4'd9;
    localparam logic [3:0] ST_HMSINC = 4'd10;
    localparam logic [3:0] ST_ARM    = 4'd11;
    localparam logic [3:0] ST_CUR    = 4'd12;
    localparam logic [3:0] ST_OLD    = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_issued;
    logic       n_issued;
    logic [3:0] div_next;

    always_comb begin
        n_state       = r_state;
        n_issued      = r_issued;
        div_next      = ST_FIN;
        o_cmd         = '0;
        o_cmd.div_sel = tts_pkg::SEL_NONE;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DISP;
                end
            end
            ST_DISP: begin
                case (i_sts.kind) inside
                    tts_pkg::KIND_TICK:                         n_state = ST_PHASE;
                    tts_pkg::KIND_ARM_A, tts_pkg::KIND_ARM_B:   n_state = ST_ARM;
                    tts_pkg::KIND_KILL_B, tts_pkg::KIND_MARK: begin
                        o_cmd.apply = 1'b1;
                        n_state     = ST_FIN;
                    end
                    tts_pkg::KIND_ELAPSED, tts_pkg::KIND_DELTA: n_state = ST_CUR;
                    default:                                    n_state = ST_FIN;
                endcase
            end
            ST_PHASE: begin
                o_cmd.div_sel = tts_pkg::SEL_PHASE;
                div_next      = ST_PCHK;
            end
            ST_PCHK: begin
                n_state = i_sts.phase_zero ? ST_TICK : ST_FIN;
            end
            ST_TICK: begin
                o_cmd.div_sel = tts_pkg::SEL_TICK;
                div_next      = ST_SPER;
            end
            ST_SPER: begin
                o_cmd.div_sel = tts_pkg::SEL_SPER;
                div_next      = ST_HPER;
            end
            ST_HPER: begin
                o_cmd.div_sel = tts_pkg::SEL_HPER;
                div_next      = ST_SECCHK;
            end
            ST_SECCHK: begin
                o_cmd.div_sel = tts_pkg::SEL_SECCHK;
                div_next      = ST_HMSCHK;
            end
            ST_HMSCHK: begin
                o_cmd.div_sel = tts_pkg::SEL_HMSCHK;
                div_next      = ST_SECINC;
            end
            ST_SECINC: begin
                o_cmd.div_sel = tts_pkg::SEL_SECINC;
                div_next      = ST_HMSINC;
            end
            ST_HMSINC: begin
                o_cmd.div_sel = tts_pkg::SEL_HMSINC;
                div_next      = ST_FIN;
            end
            ST_ARM: begin
                o_cmd.div_sel = tts_pkg::SEL_ARM;
                div_next      = ST_FIN;
            end
            ST_CUR: begin
                o_cmd.div_sel = tts_pkg::SEL_CUR;
                div_next      = ST_OLD;
            end
            ST_OLD: begin
                o_cmd.div_sel = tts_pkg::SEL_OLD;
                div_next      = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // shared divider handshake for every divide step
        if (o_cmd.div_sel != tts_pkg::SEL_NONE) begin
            if (!r_issued) begin
                o_cmd.div_start = 1'b1;
                n_issued        = 1'b1;
            end else if (i_sts.div_done) begin
                n_issued = 1'b0;
                n_state  = div_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: hdl/tts_dp.sv
module tts_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [tts_pkg::DUR_W-1:0]           i_in_dur,
    input  logic [tts_pkg::KIND_W-1:0]          i_in_kind,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tts_pkg::OUT_TDATA_W-1:0]     o_out_data,
    input  tts_pkg::t_ctrl_cmd                  i_cmd,
    output tts_pkg::t_ctrl_sts                  o_sts
);

    localparam int DW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;
    localparam int OW = tts_pkg::OUT_W;

    // configuration registers
    logic [7:0]  r_sub_divide;
    logic [15:0] r_tick_wrap;
    logic [15:0] r_sec_wrap;
    logic [15:0] r_hms_wrap;
    logic [6:0]  r_tick_ms;

    // timer state
    logic [7:0]             r_phase;
    logic [COUNT_WIDTH-1:0] r_tick;
    logic [COUNT_WIDTH-1:0] r_sec;
    logic [COUNT_WIDTH-1:0] r_hms;
    logic [15:0]            r_a_left;
    logic [15:0]            r_b_left;
    logic [COUNT_WIDTH-1:0] r_mark;
    logic [COUNT_WIDTH-1:0] r_last;

    // per-request work registers
    logic [tts_pkg::KIND_W-1:0] r_kind;
    logic [tts_pkg::DUR_W-1:0]  r_dur;
    logic                       r_a_fired;
    logic                       r_b_fired;
    logic [9:0]                 r_sper;
    logic [6:0]                 r_hper;
    logic                       r_sec_hit;
    logic                       r_hms_hit;
    logic [COUNT_WIDTH-1:0]     r_cur;
    logic [COUNT_WIDTH-1:0]     r_old;

    // result register
    logic                          r_out_valid;
    logic [tts_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [6:0]    tms_eff;
    logic [7:0]    div_eff;
    logic [DW-1:0] w_mod;
    logic [DW-1:0] sec_mod;
    logic [DW-1:0] hms_mod;
    logic [DW-1:0] div_a;
    logic [DW-1:0] div_b;
    logic          div_done;
    logic          div_busy;
    logic [DW-1:0] div_quot;
    logic [DW-1:0] div_rem;
    logic          out_free;

    function automatic logic [DW-1:0] eff_mod(input logic [15:0] wrap_val);
        logic [DW-1:0] m;
        logic [DW-1:0] cap;
        begin
            m       = (wrap_val == 16'd0) ? (DW'(1) << 16) : DW'(wrap_val);
            cap     = DW'(1) << COUNT_WIDTH;
            eff_mod = (m > cap) ? cap : m;
        end
    endfunction

    // zero means one for the divisors
    assign tms_eff = (r_tick_ms == 7'd0) ? 7'd1 : r_tick_ms;
    assign div_eff = (r_sub_divide == 8'd0) ? 8'd1 : r_sub_divide;
    assign w_mod   = eff_mod(r_tick_wrap);
    assign sec_mod = eff_mod(r_sec_wrap);
    assign hms_mod = eff_mod(r_hms_wrap);

    // divider operand select
    always_comb begin
        div_a = '0;
        div_b = DW'(1);
        case (i_cmd.div_sel)
            tts_pkg::SEL_PHASE: begin
                div_a = DW'(r_phase) + DW'(1);
                div_b = DW'(div_eff);
            end
            tts_pkg::SEL_TICK: begin
                div_a = DW'(r_tick) + DW'(1);
                div_b = w_mod;
            end
            tts_pkg::SEL_SPER: begin
                div_a = DW'(tts_pkg::MS_PER_SEC);
                div_b = DW'(tms_eff);
            end
            tts_pkg::SEL_HPER: begin
                div_a = DW'(tts_pkg::MS_PER_100MS);
                div_b = DW'(tms_eff);
            end
            tts_pkg::SEL_SECCHK: begin
                div_a = DW'(r_tick);
                div_b = DW'(r_sper);
            end
            tts_pkg::SEL_HMSCHK: begin
                div_a = DW'(r_tick);
                div_b = DW'(r_hper);
            end
            tts_pkg::SEL_SECINC: begin
                div_a = DW'(r_sec) + DW'(1);
                div_b = sec_mod;
            end
            tts_pkg::SEL_HMSINC: begin
                div_a = DW'(r_hms) + DW'(1);
                div_b = hms_mod;
            end
            tts_pkg::SEL_ARM: begin
                div_a = DW'(r_dur);
                div_b = DW'(tms_eff);
            end
            tts_pkg::SEL_CUR: begin
                div_a = DW'(r_tick);
                div_b = w_mod;
            end
            tts_pkg::SEL_OLD: begin
                div_a = (r_kind == tts_pkg::KIND_DELTA) ? DW'(r_last) : DW'(r_mark);
                div_b = w_mod;
            end
            default: begin
                div_a = '0;
                div_b = DW'(1);
            end
        endcase
    end

    tts_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_divide <= tts_pkg::RST_SUB_DIVIDE;
            r_tick_wrap  <= tts_pkg::RST_TICK_WRAP;
            r_sec_wrap   <= tts_pkg::RST_SEC_WRAP;
            r_hms_wrap   <= tts_pkg::RST_HMS_WRAP;
            r_tick_ms    <= tts_pkg::RST_TICK_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tts_pkg::CFG_SUB_DIVIDE: r_sub_divide <= i_cfg_data[7:0];
                tts_pkg::CFG_TICK_WRAP:  r_tick_wrap  <= i_cfg_data;
                tts_pkg::CFG_SEC_WRAP:   r_sec_wrap   <= i_cfg_data;
                tts_pkg::CFG_HMS_WRAP:   r_hms_wrap   <= i_cfg_data;
                tts_pkg::CFG_TICK_MS:    r_tick_ms    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // timer state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_tick   <= '0;
            r_sec    <= '0;
            r_hms    <= '0;
            r_a_left <= '0;
            r_b_left <= '0;
            r_mark   <= '0;
            r_last   <= '0;
        end else begin
            if (i_cmd.apply) begin
                if (r_kind == tts_pkg::KIND_KILL_B) begin
                    r_b_left <= '0;
                end
                if (r_kind == tts_pkg::KIND_MARK) begin
                    r_mark <= r_tick;
                end
            end
            if (div_done) begin
                case (i_cmd.div_sel)
                    tts_pkg::SEL_PHASE: r_phase <= div_rem[7:0];
                    tts_pkg::SEL_TICK: begin
                        r_tick <= div_rem[COUNT_WIDTH-1:0];
                        if (r_a_left != 16'd0) begin
                            r_a_left <= r_a_left - 16'd1;
                        end
                        if (r_b_left != 16'd0) begin
                            r_b_left <= r_b_left - 16'd1;
                        end
                    end
                    tts_pkg::SEL_SECINC: begin
                        if (r_sec_hit) begin
                            r_sec <= div_rem[COUNT_WIDTH-1:0];
                        end
                    end
                    tts_pkg::SEL_HMSINC: begin
                        if (r_hms_hit) begin
                            r_hms <= div_rem[COUNT_WIDTH-1:0];
                        end
                    end
                    tts_pkg::SEL_ARM: begin
                        if (r_kind == tts_pkg::KIND_ARM_A) begin
                            r_a_left <= div_quot[15:0];
                        end else begin
                            r_b_left <= div_quot[15:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.load_out && r_kind == tts_pkg::KIND_DELTA) begin
                r_last <= r_tick;
            end
        end
    end

    // per-request work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind    <= i_in_kind;
            r_dur     <= i_in_dur;
            r_a_fired <= 1'b0;
            r_b_fired <= 1'b0;
        end
        if (div_done) begin
            case (i_cmd.div_sel)
                tts_pkg::SEL_TICK: begin
                    r_a_fired <= (r_a_left == 16'd1);
                    r_b_fired <= (r_b_left == 16'd1);
                end
                tts_pkg::SEL_SPER:   r_sper <= (div_quot == '0) ? 10'd1 : div_quot[9:0];
                tts_pkg::SEL_HPER:   r_hper <= (div_quot == '0) ? 7'd1 : div_quot[6:0];
                tts_pkg::SEL_SECCHK: r_sec_hit <= (div_rem == DW'(tts_pkg::SEC_PHASE));
                tts_pkg::SEL_HMSCHK: r_hms_hit <= (div_rem == DW'(tts_pkg::HMS_PHASE));
                tts_pkg::SEL_CUR:    r_cur <= div_rem[COUNT_WIDTH-1:0];
                tts_pkg::SEL_OLD:    r_old <= div_rem[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // elapsed ms and signed tick delta from the reduced counts
    logic [DW-1:0]   cur_w;
    logic [DW-1:0]   old_w;
    logic [DW-1:0]   el_d;
    logic [22:0]     el_prod;
    logic signed [DW+1:0] w_s;
    logic signed [DW+1:0] h_s;
    logic signed [DW+1:0] dl_t;
    logic signed [DW+1:0] dl_d;
    logic signed [DW+1:0] dl_r;
    logic [OW-1:0]   elapsed;
    logic [OW-1:0]   delta;
    logic [31:0]     tick_ext;
    logic [31:0]     sec_ext;
    logic [31:0]     hms_ext;

    assign cur_w   = DW'(r_cur);
    assign old_w   = DW'(r_old);
    assign el_d    = (cur_w >= old_w) ? (cur_w - old_w) : (cur_w + w_mod - old_w);
    assign el_prod = el_d[15:0] * tms_eff;

    assign w_s  = signed'({2'b00, w_mod});
    assign h_s  = signed'({3'b000, w_mod[DW-1:1]});
    assign dl_t = signed'({2'b00, cur_w}) + h_s - signed'({2'b00, old_w});
    always_comb begin
        if (dl_t < 0) begin
            dl_d = dl_t + w_s;
        end else if (dl_t >= w_s) begin
            dl_d = dl_t - w_s;
        end else begin
            dl_d = dl_t;
        end
    end
    assign dl_r = dl_d - h_s;

    assign elapsed  = (r_kind == tts_pkg::KIND_ELAPSED) ? el_prod[15:0] : '0;
    assign delta    = (r_kind == tts_pkg::KIND_DELTA) ? dl_r[15:0] : '0;
    assign tick_ext = 32'(r_tick);
    assign sec_ext  = 32'(r_sec);
    assign hms_ext  = 32'(r_hms);

    // result register, free when empty or being taken
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {5'b00000, delta, elapsed, r_b_fired, r_a_fired,
                           (r_b_left != 16'd0), sec_ext[15:0], hms_ext[15:0],
                           tick_ext[15:0]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.div_done   = div_done;
    assign o_sts.div_busy   = div_busy;
    assign o_sts.kind       = r_kind;
    assign o_sts.phase_zero = (r_phase == 8'd0);
    assign o_sts.out_free   = out_free;

endmodule

// File: hdl/tick_timer_with_oneshots_core.sv
// System tick timer with two one-shot timers.
// Requests enter on the s_axis channel: tuser carries the kind (hardware tick,
// arm A, arm B, kill B, mark, elapsed query, delta query), tdata the duration
// in ms for arm requests. Every request yields exactly one result on m_axis
// carrying the tick, 100 ms and seconds counts, timer B alive, the two fired
// flags, elapsed ms and the signed tick delta.
// Registers are to be written through the cfg port only while no request is
// in flight; the block itself does not enforce this. Each request is handled
// alone by a sequencer driving one shared restoring divider of width
// DW = max(COUNT_WIDTH+1, 17), which finishes early when the dividend is
// already below the divisor. A hardware tick runs the phase divide, and only
// when the phase wraps to zero does it go on as a divided tick, which runs 8
// divides in all; arm requests run one divide, queries two, and kill and mark
// none. A finished result sits in an output register; a stalled receiver
// holds the sequencer in its final step, while the next request is accepted
// as soon as the result is parked. Reset clears all counts and timers and
// loads the register defaults.
module tick_timer_with_oneshots_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request channel
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [tts_pkg::DUR_W-1:0]           i_s_axis_tdata,  // duration_ms
    input  logic [tts_pkg::KIND_W-1:0]          i_s_axis_tuser,  // kind
    // result channel
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tick_count, hundred_ms_count, second_count, timer_b_alive,
    // timer_a_fired, timer_b_fired, elapsed_ms, delta_ticks, zero pad
    output logic [tts_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    tts_pkg::t_ctrl_cmd cmd;
    tts_pkg::t_ctrl_sts sts;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tts_dp #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_dur    (i_s_axis_tdata),
        .i_in_kind   (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // an accepted request takes the sequencer out of idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted but sequencer stayed idle");

    // divider is never restarted while iterating
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // a divide result only lands in a divide step
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |-> (cmd.div_sel != tts_pkg::SEL_NONE))
        else $error("divide result outside a divide step");

    // a parked result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overwritten");

endmodule
